// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg - shared types and constants for the UTF-8 to UTF-16 decoder
// Word types for both channels, the per-byte result bundle and the
// code point limits used by the sequence checks.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [20:0] MAX_CODE_POINT   = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST       = 21'h00D800;
    localparam logic [20:0] SURR_LAST        = 21'h00DFFF;
    localparam logic [20:0] SUPP_BASE        = 21'h010000;
    localparam logic [5:0]  HIGH_SURR_TAG    = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG     = 6'b110111;

    // most units one input byte can release
    localparam int unsigned MAX_UNITS = 4;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        replaced;
        logic        string_done;
    } t_out_word;

    // all units released by one byte, oldest in slot 0
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] unit;
        logic [MAX_UNITS-1:0]       rep;
        logic [2:0]                 count;
        logic                       done;
    } t_bundle;

    // smallest legal value for a sequence with the given continuation count
    function automatic logic [20:0] least_value(input logic [1:0] len);
        logic [20:0] v;
        case (len)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = 21'h000000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/utf8_to_utf16_decoder_top.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top - UTF-8 byte stream to UTF-16 code units
//
//   channel | dir | handshake                  | word
//   --------+-----+----------------------------+---------------------------
//   in      | in  | i_in_valid / o_in_ready    | byte_value, end_of_string
//   out     | out | o_out_valid / i_out_ready  | code_unit, replaced,
//           |     |                            | string_done
//
// A byte is decoded in the cycle it is accepted; its units sit in the
// result register from the next cycle. Units leave one per cycle while
// i_out_ready is high; a byte giving several units holds the input until
// its last unit is taken; other bytes flow at one per cycle unless held.
// o_in_ready is high when the result register is empty or its final unit
// is being taken this cycle.
// Reset (synchronous, active low) closes any open sequence and empties
// the result register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  u8u16_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output u8u16_pkg::t_out_word o_out_word
);
    import u8u16_pkg::*;

    t_bundle bundle;
    logic    advance;

    // word accepted: state steps and the bundle is loaded together
    assign advance = i_in_valid && o_in_ready;

    u8u16_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (i_in_word),
        .o_bundle  (bundle)
    );

    u8u16_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_bundle   (bundle),
        .i_ready    (i_out_ready),
        .o_valid    (o_out_valid),
        .o_word     (o_out_word),
        .o_can_load (o_in_ready)
    );

endmodule

// ===== src/u8u16_decode.sv =====
// ----------------------------------------------------------------------------
// u8u16_decode - sequence state and per-byte decode
// Holds the open-sequence state and turns each accepted byte into a
// bundle of zero to four UTF-16 units.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  u8u16_pkg::t_in_word i_word,
    output u8u16_pkg::t_bundle  o_bundle
);
    import u8u16_pkg::*;

    logic [1:0]  r_exp, n_exp;
    logic [1:0]  r_seen, n_seen;
    logic [20:0] r_cp, n_cp;

    logic [7:0]  b;
    logic        last;
    logic        cont;
    logic        fresh;
    logic        lead;
    logic [20:0] cp_sh;
    logic [19:0] supp;
    logic [2:0]  pre;
    logic [1:0]  t_cnt;
    logic [15:0] t0;
    logic        t0_rep;
    logic [15:0] t1;
    logic [2:0]  tail_idx;

    assign b     = i_word.byte_value;
    assign last  = i_word.end_of_string;
    assign cont  = (b[7:6] == 2'b10);
    assign cp_sh = {r_cp[14:0], b[5:0]};
    assign supp  = 20'(cp_sh - SUPP_BASE);

    always_comb begin
        n_exp  = r_exp;
        n_seen = r_seen;
        n_cp   = r_cp;
        pre    = 3'd0;
        t_cnt  = 2'd0;
        t0     = '0;
        t0_rep = 1'b0;
        t1     = '0;
        fresh  = 1'b0;
        lead   = 1'b0;

        if (r_exp != 2'd0) begin
            if (cont) begin
                n_cp   = cp_sh;
                n_seen = r_seen + 2'd1;
                if (n_seen >= r_exp) begin
                    n_exp  = 2'd0;
                    n_seen = 2'd0;
                    n_cp   = '0;
                    if (cp_sh < least_value(r_exp) || cp_sh > MAX_CODE_POINT ||
                        (cp_sh >= SURR_FIRST && cp_sh <= SURR_LAST)) begin
                        pre = {1'b0, r_exp} + 3'd1;
                    end else if (cp_sh >= SUPP_BASE) begin
                        t_cnt = 2'd2;
                        t0    = {HIGH_SURR_TAG, supp[19:10]};
                        t1    = {LOW_SURR_TAG, supp[9:0]};
                    end else begin
                        t_cnt = 2'd1;
                        t0    = cp_sh[15:0];
                    end
                end else if (last) begin
                    pre = {1'b0, n_seen} + 3'd1;
                end
            end else begin
                // broken sequence: flush what is buffered, then decode afresh
                pre    = {1'b0, r_seen} + 3'd1;
                n_exp  = 2'd0;
                n_seen = 2'd0;
                n_cp   = '0;
                fresh  = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            if (!b[7]) begin
                t_cnt = 2'd1;
                t0    = {8'h00, b};
            end else if (b[7:5] == 3'b110) begin
                lead  = 1'b1;
                n_exp = 2'd1;
                n_cp  = {16'h0000, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
                lead  = 1'b1;
                n_exp = 2'd2;
                n_cp  = {17'h00000, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
                lead  = 1'b1;
                n_exp = 2'd3;
                n_cp  = {18'h00000, b[2:0]};
            end else begin
                t_cnt  = 2'd1;
                t0     = REPLACEMENT_CHAR;
                t0_rep = 1'b1;
            end
            n_seen = 2'd0;
            if (lead && last) begin
                t_cnt  = 2'd1;
                t0     = REPLACEMENT_CHAR;
                t0_rep = 1'b1;
            end
        end

        if (last) begin
            n_exp  = 2'd0;
            n_seen = 2'd0;
            n_cp   = '0;
        end
    end

    // lay out replacements first, then the tail units
    always_comb begin
        o_bundle       = '0;
        o_bundle.count = pre + {1'b0, t_cnt};
        o_bundle.done  = last;
        tail_idx       = '0;
        for (int i = 0; i < MAX_UNITS; i++) begin
            tail_idx = 3'(i) - pre;
            if (3'(i) < pre) begin
                o_bundle.unit[i] = REPLACEMENT_CHAR;
                o_bundle.rep[i]  = 1'b1;
            end else if (tail_idx == 3'd0) begin
                o_bundle.unit[i] = t0;
                o_bundle.rep[i]  = t0_rep;
            end else begin
                o_bundle.unit[i] = t1;
                o_bundle.rep[i]  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= '0;
            r_seen <= '0;
            r_cp   <= '0;
        end else if (i_advance) begin
            r_exp  <= n_exp;
            r_seen <= n_seen;
            r_cp   <= n_cp;
        end
    end

endmodule

// ===== src/u8u16_out_buf.sv =====
// ----------------------------------------------------------------------------
// u8u16_out_buf - result register and unit serialiser
// Holds one byte's bundle and hands its units out one word per cycle while i_ready is high.
// ----------------------------------------------------------------------------
module u8u16_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  u8u16_pkg::t_bundle  i_bundle,
    input  logic                i_ready,
    output logic                o_valid,
    output u8u16_pkg::t_out_word o_word,
    output logic                o_can_load
);
    import u8u16_pkg::*;

    t_bundle    r_bundle;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       at_last;

    assign at_last    = ({1'b0, r_idx} == r_bundle.count - 3'd1);
    assign o_valid    = r_busy;
    assign o_can_load = !r_busy || (i_ready && at_last);

    assign o_word.code_unit   = r_bundle.unit[r_idx];
    assign o_word.replaced    = r_bundle.rep[r_idx];
    assign o_word.string_done = r_bundle.done && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (i_load) begin
            r_busy <= (i_bundle.count != 3'd0);
            r_idx  <= '0;
        end else if (r_busy && i_ready) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bundle <= i_bundle;
        end
    end

endmodule

// ===== test/utf8_to_utf16_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder_top_tb - self-checking bench for the UTF-8 decoder
// Feeds short directed strings and then random, mostly well-formed UTF-8
// strings through the input channel. A behavioural decoder predicts every
// UTF-16 unit, and each output word is checked field by field in order.
// Both sides idle at random, and the receiver makes one long hold-off.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder_top_tb;
    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_HOLD     = 150;
    localparam int HOLD_AFTER    = 40;   // units checked before the long hold-off
    localparam int RANDOM_BYTES  = 200;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_word out_word;

    utf8_to_utf16_decoder_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_in_word   byte_words[$];      // words still to be offered
    logic [7:0] str_bytes[$];       // string being assembled
    t_out_word  step_units[$];      // units released by the byte being decoded
    t_out_word  expected_units[$];  // predicted units not yet seen on the output

    // decoder state held by the predictor
    logic [1:0]  seq_need = 2'd0;
    logic [1:0]  seq_have = 2'd0;
    logic [20:0] seq_bits = 21'd0;

    int cycles         = 0;
    int send_gap       = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    int strings_queued = 0;
    int bytes_sent     = 0;
    int units_checked  = 0;
    int subs_seen      = 0;
    int halves_seen    = 0;
    int mismatches     = 0;
    t_out_word want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    // smallest code point a sequence with this many continuations may carry
    function automatic int shortest_floor(input int conts);
        case (conts)
            1:       return 'h80;
            2:       return 'h800;
            3:       return 'h10000;
            default: return 0;
        endcase
    endfunction

    function automatic void emit_unit(input logic [15:0] cu, input logic rep);
        t_out_word u;
        u.code_unit   = cu;
        u.replaced    = rep;
        u.string_done = 1'b0;
        step_units = {step_units, u};
    endfunction

    function automatic void emit_subs(input int n);
        for (int k = 0; k < n; k++)
            emit_unit(REPLACEMENT_CHAR, 1'b1);
    endfunction

    function automatic void close_seq();
        seq_need = 2'd0;
        seq_have = 2'd0;
        seq_bits = 21'd0;
    endfunction

    // byte seen with no sequence open: ASCII, a lead, or junk
    function automatic void open_byte(input logic [7:0] b, input logic last);
        logic lead;
        lead = 1'b1;
        if (b[7] == 1'b0) begin
            emit_unit({8'h00, b}, 1'b0);
            lead = 1'b0;
        end else if (b[7:5] == 3'b110) begin
            seq_need = 2'd1;
            seq_bits = {16'd0, b[4:0]};
        end else if (b[7:4] == 4'b1110) begin
            seq_need = 2'd2;
            seq_bits = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
            seq_need = 2'd3;
            seq_bits = {18'd0, b[2:0]};
        end else begin
            // stray continuation or 0xF8 and up
            emit_unit(REPLACEMENT_CHAR, 1'b1);
            lead = 1'b0;
        end
        if (lead) begin
            seq_have = 2'd0;
            // a lead cannot be the last byte of a string
            if (last) begin
                emit_unit(REPLACEMENT_CHAR, 1'b1);
                close_seq();
            end
        end
    endfunction

    // last continuation in: range, overlong and surrogate checks happen here
    function automatic void finish_seq();
        logic [20:0] v;
        logic [20:0] off;
        v = seq_bits;
        if (v < 21'(shortest_floor(int'(seq_need))) || v > MAX_CODE_POINT
                || (v >= SURR_FIRST && v <= SURR_LAST)) begin
            emit_subs(int'(seq_need) + 1);
        end else if (v >= SUPP_BASE) begin
            off = v - SUPP_BASE;
            emit_unit({HIGH_SURR_TAG, off[19:10]}, 1'b0);
            emit_unit({LOW_SURR_TAG, off[9:0]}, 1'b0);
        end else begin
            emit_unit(v[15:0], 1'b0);
        end
        close_seq();
    endfunction

    function automatic void decode_byte(input t_in_word w);
        step_units.delete();
        if (seq_need != 2'd0) begin
            if (w.byte_value[7:6] == 2'b10) begin
                seq_bits = {seq_bits[14:0], w.byte_value[5:0]};
                seq_have = seq_have + 2'd1;
                if (seq_have >= seq_need) begin
                    finish_seq();
                end else if (w.end_of_string) begin
                    emit_subs(int'(seq_have) + 1);
                    close_seq();
                end
            end else begin
                // broken sequence: flush it, then take the byte afresh
                emit_subs(int'(seq_have) + 1);
                close_seq();
                open_byte(w.byte_value, w.end_of_string);
            end
        end else begin
            open_byte(w.byte_value, w.end_of_string);
        end
        if (w.end_of_string) begin
            close_seq();
            if (step_units.size() > 0)
                step_units[step_units.size() - 1].string_done = 1'b1;
        end
        foreach (step_units[k])
            expected_units = {expected_units, step_units[k]};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    function automatic void add_seq(input logic [20:0] cp, input int len);
        case (len)
            1: str_bytes = {str_bytes, {1'b0, cp[6:0]}};
            2: begin
                str_bytes = {str_bytes, {3'b110, cp[10:6]}};
                str_bytes = {str_bytes, {2'b10, cp[5:0]}};
            end
            3: begin
                str_bytes = {str_bytes, {4'b1110, cp[15:12]}};
                str_bytes = {str_bytes, {2'b10, cp[11:6]}};
                str_bytes = {str_bytes, {2'b10, cp[5:0]}};
            end
            default: begin
                str_bytes = {str_bytes, {5'b11110, cp[20:18]}};
                str_bytes = {str_bytes, {2'b10, cp[17:12]}};
                str_bytes = {str_bytes, {2'b10, cp[11:6]}};
                str_bytes = {str_bytes, {2'b10, cp[5:0]}};
            end
        endcase
    endfunction

    // a code point in the range of the given encoding length; for three bytes it may be a surrogate value
    function automatic logic [20:0] legal_cp(input int len);
        case (len)
            1:       return 21'($urandom_range(0, 'h7F));
            2:       return 21'($urandom_range('h80, 'h7FF));
            3:       return 21'($urandom_range('h800, 'hFFFF));
            default: return 21'($urandom_range('h10000, 'h10FFFF));
        endcase
    endfunction

    // hand the assembled string over, end mark on its final byte
    function automatic void queue_string();
        t_in_word w;
        foreach (str_bytes[k]) begin
            w.byte_value    = str_bytes[k];
            w.end_of_string = (k == str_bytes.size() - 1);
            byte_words = {byte_words, w};
        end
        strings_queued++;
    endfunction

    function automatic void add_random_string();
        int n_seq;
        int kind;
        int len;
        str_bytes.delete();
        n_seq = $urandom_range(1, 6);
        repeat (n_seq) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (kind < 60) begin
                add_seq(legal_cp(len), len);
            end else if (kind < 70) begin
                // overlong form
                len = $urandom_range(2, 4);
                add_seq(21'($urandom_range(0, shortest_floor(len - 1) - 1)), len);
            end else if (kind < 78) begin
                // beyond the code space, or a surrogate value
                if ($urandom_range(0, 1))
                    add_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
                else
                    add_seq(21'($urandom_range(int'(SURR_FIRST), int'(SURR_LAST))), 3);
            end else if (kind < 88) begin
                // cut short; the next non-continuation byte or the string end breaks it
                len = $urandom_range(2, 4);
                add_seq(legal_cp(len), len);
                repeat ($urandom_range(1, len - 1))
                    void'(str_bytes.pop_back());
            end else begin
                str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
            end
        end
        queue_string();
    endfunction

    // idle length; no idling while bits 9:8 of the cycle counter are zero
    function automatic int pick_gap();
        int r;
        if (cycles[9:8] == 2'b00)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers words from byte_words, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && in_ready) begin
                decode_byte(in_word);
                bytes_sent <= bytes_sent + 1;
            end
            if (in_valid && !in_ready) begin
                // word held until taken
            end else if (send_gap != 0) begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (byte_words.size() != 0) begin
                in_valid <= 1'b1;
                in_word  <= byte_words.pop_front();
                send_gap <= pick_gap();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output side: ready pattern, with one long hold-off so the result
    // register fills and the block pushes back on its input
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (!long_hold_done && units_checked >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            out_ready      <= 1'b0;
        end else if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                hold_left <= pick_gap();
        end
    end

    // checker: each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            units_checked <= units_checked + 1;
            if (out_word.replaced)
                subs_seen <= subs_seen + 1;
            else if (out_word.code_unit[15:11] == HIGH_SURR_TAG[5:1])
                halves_seen <= halves_seen + 1;
            if (expected_units.size() == 0) begin
                $error("unexpected word: code_unit %h replaced %b string_done %b",
                       out_word.code_unit, out_word.replaced, out_word.string_done);
                mismatches++;
            end else begin
                want = expected_units.pop_front();
                if (out_word.code_unit !== want.code_unit) begin
                    $error("code_unit: expected %h, got %h",
                           want.code_unit, out_word.code_unit);
                    mismatches++;
                end
                if (out_word.replaced !== want.replaced) begin
                    $error("replaced: expected %b, got %b",
                           want.replaced, out_word.replaced);
                    mismatches++;
                end
                if (out_word.string_done !== want.string_done) begin
                    $error("string_done: expected %b, got %b",
                           want.string_done, out_word.string_done);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        // directed strings
        str_bytes = {8'h00, 8'h7F};                       // NUL and top of ASCII
        queue_string();
        str_bytes = {8'hEF, 8'hBF, 8'hBD};                // real U+FFFD, not a substitution
        queue_string();
        str_bytes = {8'hF4, 8'h8F, 8'hBF, 8'hBF};         // U+10FFFF as a surrogate pair
        queue_string();
        // surrogate value, overlong via C0, stray continuation
        str_bytes = {8'hED, 8'hA0, 8'h80, 8'hC0, 8'h80, 8'h80};
        queue_string();
        str_bytes = {8'hFF, 8'hE2, 8'h41};                // junk byte, broken sequence
        queue_string();
        str_bytes = {8'hF5, 8'h80, 8'h80, 8'h80};         // F5 lead, out of range at the end
        queue_string();
        str_bytes = {8'hF0, 8'h90};                       // string ends mid-sequence
        queue_string();
        str_bytes = {8'hC3};                              // lead as final byte
        queue_string();

        while (byte_words.size() < RANDOM_BYTES + 25)
            add_random_string();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(byte_words.size() == 0 && !in_valid && expected_units.size() == 0)
               && cycles < CYCLE_LIMIT)
            @(negedge i_clk);

        if (cycles >= CYCLE_LIMIT) begin
            $display("timed out after %0d cycles, %0d words still expected",
                     cycles, expected_units.size());
            $display("utf8_to_utf16_decoder_top regression: fail");
            $finish;
        end else begin
            // catch any stray words after the last prediction
            repeat (SETTLE_CYCLES) @(negedge i_clk);
            if (expected_units.size() != 0) begin
                $error("%0d predicted words never arrived", expected_units.size());
                mismatches++;
            end
            $display("%0d strings, %0d bytes decoded into %0d UTF-16 units",
                     strings_queued, bytes_sent, units_checked);
            $display("%0d substitutions, %0d surrogate halves, %0d mismatches",
                     subs_seen, halves_seen, mismatches);
            if (mismatches == 0)
                $display("utf8_to_utf16_decoder_top regression: pass");
            else
                $display("utf8_to_utf16_decoder_top regression: fail");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_out_buf.sv
src/utf8_to_utf16_decoder_top.sv
test/utf8_to_utf16_decoder_top_tb.sv
